>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the PID regulator.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/pidaw_pkg.sv
// Package for the PID regulator: word widths, command and register codes,
// reset values and the saturation helper. No dependencies.
package pidaw_pkg;

  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int RATE_W  = 31;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int WIDE_W  = PROD_W - FRAC_W;
  localparam int ACC_W   = WORD_W + 3;
  localparam int IDX_W   = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [RATE_W-1:0]        rate_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // register indexes
  localparam idx_t REG_KP     = 3'd0;
  localparam idx_t REG_KI     = 3'd1;
  localparam idx_t REG_KD     = 3'd2;
  localparam idx_t REG_TARGET = 3'd3;
  localparam idx_t REG_LIM_LO = 3'd4;
  localparam idx_t REG_LIM_HI = 3'd5;
  localparam idx_t REG_PERIOD = 3'd6;
  localparam idx_t REG_RATE   = 3'd7;

  // reset values
  localparam word_t RST_KP     = 32'sd65536;
  localparam word_t RST_KI     = 32'sd6554;
  localparam word_t RST_KD     = 32'sd3277;
  localparam word_t RST_TARGET = 32'sd1638400;
  localparam word_t RST_LIM_LO = -32'sd6553600;
  localparam word_t RST_LIM_HI = 32'sd6553600;
  localparam rate_t RST_PERIOD = 31'd655;
  localparam rate_t RST_RATE   = 31'd6553600;

  localparam wide_t WIDE_MAX = wide_t'({1'b0, {(WORD_W-1){1'b1}}});
  localparam wide_t WIDE_MIN = -WIDE_MAX - wide_t'(1);

  // saturate a wide signed value to one word
  function automatic word_t sat_word(input wide_t v);
    word_t r;
    if (v > WIDE_MAX) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < WIDE_MIN) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/pidaw_mul.sv
// Shared fixed-point multiplier: registered signed product, then shift,
// truncation toward zero and saturation to one word. Uses pidaw_pkg.
module pidaw_mul (
  input  logic           clk_i,
  input  logic           en_i,
  input  pidaw_pkg::word_t a_i,
  input  pidaw_pkg::word_t b_i,
  output pidaw_pkg::word_t q_o
);
  import pidaw_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  wide_t                    shifted;
  wide_t                    trunc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  // arithmetic shift floors; a negative product with fraction bits moves up one
  always_comb begin
    shifted = prod_q[PROD_W-1:FRAC_W];
    trunc   = (prod_q[PROD_W-1] && (|prod_q[FRAC_W-1:0])) ? shifted + wide_t'(1) : shifted;
  end

  assign q_o = sat_word(trunc);

endmodule

>>> rtl/pid_controller_antiwindup.sv
// PID regulator with integral clamp, signed Q16.16, one shared multiplier.
// A sample item accepted in S_IDLE steps through S_ERR, S_DIF, S_INT, S_DT,
// S_P, S_I and S_D, which registers the result, waiting while the output
// register is still held by a stall. No item is taken outside S_IDLE, while the
// single multiplier steps through five products. A clear item yields no result.
// Reset (rst_ni low, async): registers to defaults, integral and last error zero.
`include "assert_macros.svh"

module pid_controller_antiwindup (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  pidaw_pkg::idx_t  cfg_idx_i,
  input  pidaw_pkg::word_t cfg_data_i,
  // input item channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  pidaw_pkg::word_t measurement_i,
  // result item channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pidaw_pkg::word_t drive_value_o
);
  import pidaw_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_ERR  = 3'd1;  // e = target - measurement
  localparam logic [2:0] S_DIF  = 3'd2;  // d = e - last_e ; mul e*period
  localparam logic [2:0] S_INT  = 3'd3;  // integral update + clamp ; mul d*rate
  localparam logic [2:0] S_DT   = 3'd4;  // dterm captured ; mul kp*e
  localparam logic [2:0] S_P    = 3'd5;  // acc = P term ; mul ki*I
  localparam logic [2:0] S_I    = 3'd6;  // acc += I term ; mul kd*dterm
  localparam logic [2:0] S_D    = 3'd7;  // acc += D term, sat, clamp, emit

  logic [2:0] state_q, state_d;

  // configuration registers
  word_t kp_q, ki_q, kd_q, target_q, lim_lo_q, lim_hi_q;
  rate_t period_q, rate_q;

  // working registers
  word_t meas_q;
  word_t err_q;
  word_t diff_q;     // holds d, then the derivative term
  word_t integ_q;
  word_t last_q;
  acc_t  acc_q;
  word_t out_q;
  logic  out_valid_q;

  // shared units
  word_t mul_a, mul_b, mul_q;
  logic  mul_en;
  acc_t  add_a, add_b, add_res;
  logic  add_sub;
  word_t add_sat;
  word_t clamp_res;

  logic in_acc;
  logic out_free;

  assign in_stall_o    = (state_q != S_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign drive_value_o = out_q;

  // limit clamp: high bound first, then low, so inverted limits end at the low bound
  function automatic word_t clamp_lim(input word_t v, input word_t lo, input word_t hi);
    word_t r;
    r = (v > hi) ? hi : v;
    r = (r < lo) ? lo : r;
    return r;
  endfunction

  // --- configuration ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= RST_KP;
      ki_q     <= RST_KI;
      kd_q     <= RST_KD;
      target_q <= RST_TARGET;
      lim_lo_q <= RST_LIM_LO;
      lim_hi_q <= RST_LIM_HI;
      period_q <= RST_PERIOD;
      rate_q   <= RST_RATE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KP:     kp_q     <= cfg_data_i;
        REG_KI:     ki_q     <= cfg_data_i;
        REG_KD:     kd_q     <= cfg_data_i;
        REG_TARGET: target_q <= cfg_data_i;
        REG_LIM_LO: lim_lo_q <= cfg_data_i;
        REG_LIM_HI: lim_hi_q <= cfg_data_i;
        REG_PERIOD: period_q <= cfg_data_i[RATE_W-1:0];
        REG_RATE:   rate_q   <= cfg_data_i[RATE_W-1:0];
        default:    ;
      endcase
    end
  end

  // --- shared multiplier: operands picked by the step ---
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      S_DIF: begin
        mul_a = err_q;
        mul_b = word_t'({1'b0, period_q});
      end
      S_INT: begin
        mul_a = diff_q;
        mul_b = word_t'({1'b0, rate_q});
      end
      S_DT: begin
        mul_a = kp_q;
        mul_b = err_q;
      end
      S_P: begin
        mul_a = ki_q;
        mul_b = integ_q;
      end
      S_I: begin
        mul_a = kd_q;
        mul_b = diff_q;
      end
      default: begin
        mul_en = 1'b0;  // hold the last product, S_D may wait on the output
      end
    endcase
  end

  pidaw_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .q_o   (mul_q)
  );

  // --- shared adder with saturation ---
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_ERR: begin
        add_a   = acc_t'(target_q);
        add_b   = acc_t'(meas_q);
        add_sub = 1'b1;
      end
      S_DIF: begin
        add_a   = acc_t'(err_q);
        add_b   = acc_t'(last_q);
        add_sub = 1'b1;
      end
      S_INT: begin
        add_a = acc_t'(integ_q);
        add_b = acc_t'(mul_q);
      end
      S_P: begin
        add_b = acc_t'(mul_q);
      end
      S_I, S_D: begin
        add_a = acc_q;
        add_b = acc_t'(mul_q);
      end
      default: ;
    endcase
    add_res   = add_sub ? (add_a - add_b) : (add_a + add_b);
    add_sat   = sat_word(wide_t'(add_res));
    clamp_res = clamp_lim(add_sat, lim_lo_q, lim_hi_q);
  end

  // --- sequencer ---
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (cmd_i == CMD_SAMPLE)) begin
          state_d = S_ERR;
        end
      end
      S_ERR: state_d = S_DIF;
      S_DIF: state_d = S_INT;
      S_INT: state_d = S_DT;
      S_DT:  state_d = S_P;
      S_P:   state_d = S_I;
      S_I:   state_d = S_D;
      S_D: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      integ_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && (cmd_i == CMD_CLEAR)) begin
        integ_q <= '0;
        last_q  <= '0;
      end
      if (state_q == S_DIF) begin
        last_q <= err_q;
      end
      if (state_q == S_INT) begin
        integ_q <= clamp_res;  // anti-windup clamp
      end
      if (state_q == S_D && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= measurement_i;
    end
    if (state_q == S_ERR) begin
      err_q <= add_sat;
    end
    if (state_q == S_DIF) begin
      diff_q <= add_sat;
    end
    if (state_q == S_DT) begin
      diff_q <= mul_q;  // derivative term replaces d
    end
    if (state_q == S_P || state_q == S_I) begin
      acc_q <= add_res;  // three-term sum kept unsaturated until the end
    end
    if (state_q == S_D && out_free) begin
      out_q <= clamp_res;
    end
  end

  // --- checks ---
  `ASSERT_IMPL(a_clear_state, in_acc && (cmd_i == CMD_CLEAR),
    ##1 (integ_q == '0) && (last_q == '0), "clear item did not zero the state")
  `ASSERT_IMPL(a_sample_starts, in_acc && (cmd_i == CMD_SAMPLE),
    ##1 (state_q == S_ERR), "sample item did not start the sequence")
  `ASSERT_IMPL(a_emit, (state_q == S_D) && out_free,
    ##1 out_valid_q && (state_q == S_IDLE), "result not emitted at end of sequence")

endmodule

>>> tb/pid_controller_antiwindup_check.sv
// Checker for the PID regulator: watches the configuration port and both item
// channels, predicts drive_value per sample item and compares in order.
// Depends on pidaw_pkg for widths, command and register codes and reset values.
`timescale 1ns / 1ps

module pid_drive_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  pidaw_pkg::idx_t  cfg_idx_i,
  input  pidaw_pkg::word_t cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             cmd_i,
  input  pidaw_pkg::word_t measurement_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  pidaw_pkg::word_t drive_value_i,
  output int               errors_o,
  output int               pending_o
);
  import pidaw_pkg::*;

  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -WORD_HI - 64'sd1;

  // shadow registers and regulator state, held wide and sign-correct
  longint kp, ki, kd, setpoint, lim_lo, lim_hi, period, rate;
  longint integ_acc, prev_err;

  word_t drive_q[$];
  word_t want;
  int    err_cnt;

  function automatic longint clip_word(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Q16.16 product, truncated toward zero, saturated
  function automatic longint fx_mul(input longint a, input longint b);
    longint prod;
    longint quot;
    prod = a * b;
    if (prod < 0) quot = -((-prod) >>> FRAC_W);
    else quot = prod >>> FRAC_W;
    return clip_word(quot);
  endfunction

  // high clamp first, so inverted limits settle on the low one
  function automatic longint bound(input longint v);
    longint r;
    r = v;
    if (r > lim_hi) r = lim_hi;
    if (r < lim_lo) r = lim_lo;
    return r;
  endfunction

  function automatic word_t step_regulator(input word_t meas);
    longint e, dlt, dterm, acc;
    e         = clip_word(setpoint - longint'(meas));
    integ_acc = bound(clip_word(integ_acc + fx_mul(e, period)));
    dlt       = clip_word(e - prev_err);
    dterm     = fx_mul(dlt, rate);
    prev_err  = e;
    acc = fx_mul(kp, e) + fx_mul(ki, integ_acc) + fx_mul(kd, dterm);
    acc = bound(clip_word(acc));
    return word_t'(acc[WORD_W-1:0]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp        = longint'(RST_KP);
      ki        = longint'(RST_KI);
      kd        = longint'(RST_KD);
      setpoint  = longint'(RST_TARGET);
      lim_lo    = longint'(RST_LIM_LO);
      lim_hi    = longint'(RST_LIM_HI);
      period    = longint'(RST_PERIOD);
      rate      = longint'(RST_RATE);
      integ_acc = 0;
      prev_err  = 0;
      drive_q.delete();
      err_cnt   = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP:     kp       = longint'(cfg_data_i);
          REG_KI:     ki       = longint'(cfg_data_i);
          REG_KD:     kd       = longint'(cfg_data_i);
          REG_TARGET: setpoint = longint'(cfg_data_i);
          REG_LIM_LO: lim_lo   = longint'(cfg_data_i);
          REG_LIM_HI: lim_hi   = longint'(cfg_data_i);
          REG_PERIOD: period   = longint'(cfg_data_i[RATE_W-1:0]);
          REG_RATE:   rate     = longint'(cfg_data_i[RATE_W-1:0]);
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_CLEAR) begin
          integ_acc = 0;
          prev_err  = 0;
        end else begin
          drive_q.push_back(step_regulator(measurement_i));
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          err_cnt++;
          $display("%0t: drive_value expected none, got %0d", $time, drive_value_i);
        end else begin
          want = drive_q.pop_front();
          if (want !== drive_value_i) begin
            err_cnt++;
            $display("%0t: drive_value expected %0d, got %0d",
                     $time, want, drive_value_i);
          end
        end
      end

      errors_o  <= err_cnt;
      pending_o <= drive_q.size();
    end
  end

endmodule

>>> tb/pid_controller_antiwindup_test.sv
// Top of the PID regulator testbench: clock, reset, configuration phases and
// item stimulus with random idling on both channels; verdict from the checker.
// Depends on pidaw_pkg, pid_controller_antiwindup and pid_drive_checker.
`timescale 1ns / 1ps

module pid_controller_antiwindup_test;
  import pidaw_pkg::*;

  // a generous multiple of the slowest run, stalls included
  localparam int CYCLE_LIMIT  = 200000;
  // longer than the block's latency, so a trailing clear item has drained
  localparam int QUIET_CYCLES = 24;
  localparam int SEGMENTS     = 10;
  localparam int SEG_ITEMS    = 50;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we = 1'b0;
  idx_t  cfg_idx = REG_KP;
  word_t cfg_data = '0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  cmd = CMD_SAMPLE;
  word_t meas = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t drive_value;

  int errors;
  int pending;
  int send_idle = 19;   // percent of cycles the sender holds back
  int recv_idle = 59;   // percent of cycles the receiver stalls
  int cycle_cnt = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pid_controller_antiwindup uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .measurement_i (meas),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .drive_value_o (drive_value)
  );

  pid_drive_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .measurement_i (meas),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .drive_value_i (drive_value),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // receiver: random stall, redrawn every cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("pid_controller_antiwindup_test: done, errors");
      $finish;
    end
  end

  // Present one item and hold it until accepted. Called just after a rising
  // edge; returns at the edge that took the item, valid still high, so a
  // back-to-back item keeps valid up without a glitch.
  task automatic drive_item(input logic c, input word_t m);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      cmd      <= 1'($urandom_range(1));
      meas     <= $urandom;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    meas     <= m;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has come out, then a
  // few more cycles in case a clear item is still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Write all eight registers, one per cycle, block idle.
  task automatic load_settings(input word_t g_p, input word_t g_i, input word_t g_d,
                               input word_t tgt, input word_t lo, input word_t hi,
                               input word_t per, input word_t rt);
    cfg_we <= 1'b1;
    cfg_idx <= REG_KP;     cfg_data <= g_p; @(posedge clk_i);
    cfg_idx <= REG_KI;     cfg_data <= g_i; @(posedge clk_i);
    cfg_idx <= REG_KD;     cfg_data <= g_d; @(posedge clk_i);
    cfg_idx <= REG_TARGET; cfg_data <= tgt; @(posedge clk_i);
    cfg_idx <= REG_LIM_LO; cfg_data <= lo;  @(posedge clk_i);
    cfg_idx <= REG_LIM_HI; cfg_data <= hi;  @(posedge clk_i);
    cfg_idx <= REG_PERIOD; cfg_data <= per; @(posedge clk_i);
    cfg_idx <= REG_RATE;   cfg_data <= rt;  @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    word_t w_max, w_min, tgt_cur, lo, hi;
    int    seg, n, r;
    w_max = 32'sh7fffffff;
    w_min = 32'sh80000000;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: reset settings first, with extreme measurements
    drive_item(CMD_SAMPLE, RST_TARGET);       // zero error
    drive_item(CMD_SAMPLE, 32'sd0);
    drive_item(CMD_SAMPLE, w_max);
    drive_item(CMD_SAMPLE, w_min);            // big error swing, derivative saturates
    drive_item(CMD_SAMPLE, w_min);
    drive_item(CMD_SAMPLE, w_max);
    drive_item(CMD_CLEAR,  w_max);            // payload ignored
    drive_item(CMD_SAMPLE, 32'sd0);
    wait_idle();

    // all-extreme registers, every product saturating unless its error factor is zero
    load_settings(w_max, w_max, w_min, w_max, w_min, w_max, w_max, w_max);
    drive_item(CMD_SAMPLE, w_min);
    drive_item(CMD_SAMPLE, w_max);
    drive_item(CMD_SAMPLE, 32'sd0);
    drive_item(CMD_CLEAR,  32'sd0);
    drive_item(CMD_SAMPLE, w_min);
    wait_idle();

    // opposite signs, smallest nonzero period and rate
    load_settings(w_min, w_min, w_max, w_min, w_min, w_max, 32'sd1, 32'sd1);
    drive_item(CMD_SAMPLE, w_max);
    drive_item(CMD_SAMPLE, w_min);
    drive_item(CMD_SAMPLE, 32'sd0);
    wait_idle();

    // inverted limits: low +100.0, high -100.0, everything ends at the low one
    load_settings(RST_KP, RST_KI, RST_KD, RST_TARGET, 32'sd6553600, -32'sd6553600,
                  32'sd655, 32'sd6553600);
    drive_item(CMD_SAMPLE, 32'sd0);
    drive_item(CMD_SAMPLE, 32'sd1638400);
    drive_item(CMD_SAMPLE, w_max);
    wait_idle();

    // zero period and rate: the integral stops changing and the derivative term vanishes
    load_settings(RST_KP, RST_KI, RST_KD, RST_TARGET, -32'sd6553600, 32'sd6553600,
                  32'sd0, 32'sd0);
    drive_item(CMD_SAMPLE, 32'sd0);
    drive_item(CMD_SAMPLE, 32'sd65536000);
    drive_item(CMD_CLEAR,  32'sd0);
    drive_item(CMD_SAMPLE, -32'sd65536000);
    wait_idle();

    // --- random segments, each under fresh settings
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_idle = 59;
        recv_idle = 19;
      end else if (seg == 7) begin
        send_idle = 0;
        recv_idle = 0;
      end

      if (seg % 3 == 0) begin
        // raw words: every bit of every register, limits possibly inverted
        tgt_cur = $urandom;
        load_settings($urandom, $urandom, $urandom, tgt_cur, $urandom, $urandom,
                      $urandom, $urandom);
      end else begin
        // plausible loop tuning so the integral clamp and output limits engage
        tgt_cur = word_t'($urandom_range(6553600)) - 32'sd3276800;
        lo = -word_t'($urandom_range(13107200, 65536));
        hi = word_t'($urandom_range(13107200, 65536));
        load_settings(
          $urandom_range(1) ? word_t'($urandom_range(262144))
                            : -word_t'($urandom_range(262144)),
          word_t'($urandom_range(131072)),
          word_t'($urandom_range(65536)),
          tgt_cur, lo, hi,
          word_t'($urandom_range(16384, 1)),
          word_t'($urandom_range(16777216, 65536)));
      end

      for (n = 0; n < SEG_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          drive_item(CMD_CLEAR, $urandom);
        end else if (r < 80) begin
          // near the setpoint: the regulator's working range
          drive_item(CMD_SAMPLE,
                     tgt_cur + word_t'($urandom_range(2621440)) - 32'sd1310720);
        end else begin
          drive_item(CMD_SAMPLE, $urandom);
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("pid_controller_antiwindup_test: done, clean");
    end else begin
      $display("pid_controller_antiwindup_test: done, errors");
    end
    $finish;
  end

endmodule

>>> pid_controller_antiwindup.f
+incdir+rtl
rtl/pidaw_pkg.sv
rtl/pidaw_mul.sv
rtl/pid_controller_antiwindup.sv
tb/pid_controller_antiwindup_check.sv
tb/pid_controller_antiwindup_test.sv
